@@ rtl/core/murmurhash2_key_hash_macros.svh @@
// assertion macros used by the hash core controller
`ifndef MURMURHASH2_KEY_HASH_MACROS_SVH
`define MURMURHASH2_KEY_HASH_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked on every clock outside reset
`define MMH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, checked on every clock outside reset
`define MMH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MMH_ASSERT_NOW(label, ante, cons, msg)
`define MMH_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/mmh_pkg.sv @@
// shared constants and control types for the hash core
`timescale 1ns / 1ps

package mmh_pkg;

   localparam logic [31:0] MixMult   = 32'h5bd1e995;
   localparam int          MixShift  = 24;
   localparam int          FinShiftA = 13;
   localparam int          FinShiftB = 15;
   localparam logic [31:0] SeedReset = 32'd5381;

   // multiplier operand select
   typedef enum logic [1:0] {
      SEL_WORD = 2'd0,
      SEL_KEY  = 2'd1,
      SEL_HASH = 2'd2,
      SEL_FIN  = 2'd3
   } mul_sel_type;

   // controller states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL_W = 6'b000010,
      ST_MUL_K = 6'b000100,
      ST_MUL_H = 6'b001000,
      ST_MUL_F = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      mul_sel_type sel;
      logic        prod_we;
      logic        hash_we;
      logic        out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_full;
      logic in_tail;
      logic in_last;
      logic cur_last;
      logic out_busy;
   } sts_type;

endpackage

@@ rtl/core/mmh_datapath.sv @@
// hash datapath: seed, running hash, shared multiplier and result register
`timescale 1ns / 1ps

module mmh_datapath (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [31:0]     csr_hash_seed,
   input  logic [31:0]     req_key_word,
   input  logic [2:0]      req_valid_bytes,
   input  logic            req_first_word,
   input  logic            req_last_word,
   input  logic [15:0]     req_key_length,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic [31:0]     rsp_hash_value,
   input  mmh_pkg::cmd_type cmd,
   output mmh_pkg::sts_type sts
);
   import mmh_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] word_ff;
   logic [31:0] prod_ff;
   logic        full_ff, last_ff;
   logic [31:0] out_ff;
   logic        out_valid_ff, out_valid_in;

   logic [31:0] tail_mask;
   logic [31:0] base_hash;
   logic [31:0] mul_a;
   logic [31:0] mul_p;
   logic        in_full, in_tail;

   // byte count decode, counts above four act as four
   assign in_full = req_valid_bytes[2];
   assign in_tail = !req_valid_bytes[2] && (req_valid_bytes[1:0] != 2'd0);

   // tail byte mask for one to three bytes
   always_comb begin
      tail_mask = 32'h0000_00ff;
      if (req_valid_bytes[1:0] == 2'd2 || req_valid_bytes[1:0] == 2'd3) begin
         tail_mask = tail_mask | 32'h0000_ff00;
      end
      if (req_valid_bytes[1:0] == 2'd3) begin
         tail_mask = tail_mask | 32'h00ff_0000;
      end
   end

   // seed register
   always_comb begin
      seed_in = seed_ff;
      if (csr_valid && csr_ready) begin
         seed_in = csr_hash_seed;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.sel)
         SEL_WORD: mul_a = word_ff;
         SEL_KEY:  mul_a = prod_ff ^ (prod_ff >> MixShift);
         SEL_HASH: mul_a = hash_ff;
         SEL_FIN:  mul_a = hash_ff ^ (hash_ff >> FinShiftA);
         default:  mul_a = word_ff;
      endcase
   end

   assign mul_p = mul_a * MixMult;

   // running hash update: reload on first word, tail bytes, fold
   always_comb begin
      base_hash = req_first_word ? (seed_ff ^ {16'd0, req_key_length}) : hash_ff;
      hash_in   = hash_ff;
      if (cmd.load) begin
         hash_in = in_tail ? (base_hash ^ (req_key_word & tail_mask)) : base_hash;
      end else if (cmd.hash_we) begin
         hash_in = mul_p ^ (full_ff ? prod_ff : 32'd0);
      end
   end

   // result valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SeedReset;
         hash_ff      <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_key_word;
         full_ff <= in_full;
         last_ff <= req_last_word;
      end
      if (cmd.prod_we) begin
         prod_ff <= mul_p;
      end
      if (cmd.out_load) begin
         out_ff <= prod_ff ^ (prod_ff >> FinShiftB);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_ff;

   assign sts.in_full  = in_full;
   assign sts.in_tail  = in_tail;
   assign sts.in_last  = req_last_word;
   assign sts.cur_last = last_ff;
   assign sts.out_busy = out_valid_ff && rsp_stall;

endmodule

@@ rtl/core/mmh_ctrl.sv @@
// hash controller: sequences the shared multiplier for each item
`timescale 1ns / 1ps
`include "murmurhash2_key_hash_macros.svh"

module mmh_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mmh_pkg::sts_type sts,
   output mmh_pkg::cmd_type cmd
);
   import mmh_pkg::*;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.sel      = SEL_WORD;
      cmd.prod_we  = 1'b0;
      cmd.hash_we  = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.in_full) begin
                  state_in = ST_MUL_W;
               end else if (sts.in_tail) begin
                  state_in = ST_MUL_H;
               end else if (sts.in_last) begin
                  state_in = ST_MUL_F;
               end
            end
         end
         ST_MUL_W: begin
            cmd.sel     = SEL_WORD;
            cmd.prod_we = 1'b1;
            state_in    = ST_MUL_K;
         end
         ST_MUL_K: begin
            cmd.sel     = SEL_KEY;
            cmd.prod_we = 1'b1;
            state_in    = ST_MUL_H;
         end
         ST_MUL_H: begin
            cmd.sel     = SEL_HASH;
            cmd.hash_we = 1'b1;
            state_in    = sts.cur_last ? ST_MUL_F : ST_IDLE;
         end
         ST_MUL_F: begin
            cmd.sel     = SEL_FIN;
            cmd.prod_we = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // sequencing checks
   `MMH_ASSERT_NEXT(a_full_starts_mix, cmd.load && sts.in_full, state_ff == ST_MUL_W, "full word did not start key mix")
   `MMH_ASSERT_NEXT(a_key_two_muls, state_ff == ST_MUL_W, state_ff == ST_MUL_K, "key mix skipped second multiply")
   `MMH_ASSERT_NEXT(a_fin_then_out, state_ff == ST_MUL_F, state_ff == ST_OUT, "final mix not followed by output")
   `MMH_ASSERT_NOW(a_no_overwrite, cmd.out_load, !sts.out_busy, "result loaded over a pending item")

endmodule

@@ rtl/core/murmurhash2_key_hash.sv @@
// MurmurHash2 32-bit key hasher, top level
//
// Keys stream in on the req_ channel as little-endian 32-bit words, first byte
// in bits 7:0. The word marked req_first_word reloads the running hash with the
// seed xor req_key_length. Full words take three multiplies, a word of one to
// three bytes takes one, and an empty word takes none. The word marked
// req_last_word adds the final mix and one item appears on the rsp_ channel.
// The seed is written through csr_valid / csr_ready; the user writes it only
// while the block is idle, which the block itself does not enforce. req_stall
// holds off the next word while the single shared 32x32 multiplier, used at
// most once per cycle, works on the current one: word, key and hash multiplies
// for a full word, the hash multiply for a tail word, final mix for a last word.
// The result sits in an output register: while rsp_stall is high it holds,
// and the block keeps accepting items until a second result is ready.
// Synchronous reset sets the seed to 5381, clears the running hash and drops
// any pending result.
`timescale 1ns / 1ps

module murmurhash2_key_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_hash_seed,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_key_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [15:0] req_key_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import mmh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // the user issues seed writes only while idle; the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer
   mmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hash datapath
   mmh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_seed   (csr_hash_seed),
      .req_key_word    (req_key_word),
      .req_valid_bytes (req_valid_bytes),
      .req_first_word  (req_first_word),
      .req_last_word   (req_last_word),
      .req_key_length  (req_key_length),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_hash_value  (rsp_hash_value),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule
